>>> rtl/uartrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART register block package
// Shared item codes, register indexes, reset values and the interrupt
// evaluation used by the UART register block with a receive FIFO.
// ----------------------------------------------------------------------------
package uartrb_pkg;

	localparam int RX_DEPTH_DEFAULT = 15;
	localparam int NUM_REGS         = 15;

	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_WRITE   = 3'd1;
	localparam logic [2:0] KIND_RX_BYTE = 3'd2;
	localparam logic [2:0] KIND_BREAK   = 3'd3;
	localparam logic [2:0] KIND_TIMEOUT = 3'd4;

	localparam logic [3:0] R_CON    = 4'd1;
	localparam logic [3:0] R_FCON   = 4'd2;
	localparam logic [3:0] R_TRSTAT = 4'd4;
	localparam logic [3:0] R_ERSTAT = 4'd5;
	localparam logic [3:0] R_FSTAT  = 4'd6;
	localparam logic [3:0] R_MSTAT  = 4'd7;
	localparam logic [3:0] R_TXH    = 4'd8;
	localparam logic [3:0] R_RXH    = 4'd9;

	localparam logic [31:0] CON_RESET    = 32'h0000_3000;
	localparam logic [31:0] TRSTAT_RESET = 32'h0000_0006;
	localparam logic [31:0] FSTAT_FULL   = 32'h0000_0100;
	localparam logic [31:0] FSTAT_CNT    = 32'h0000_000f;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [31:0] trstat;
		logic        disarm;
		logic        irq;
	} irq_eval_t;

	function automatic logic [7:0] trig_level(input logic [2:0] chan, input logic [1:0] sel);
		logic [7:0] n;
		logic [7:0] lvl;
		n = {6'd0, sel} + 8'd1;
		case (chan)
			3'd0: lvl = n << 5;
			3'd1, 3'd4: lvl = n << 3;
			3'd2, 3'd3: lvl = n << 1;
			default: lvl = 8'd0;
		endcase
		return lvl;
	endfunction

	function automatic irq_eval_t eval_irq(
		input logic [31:0] con,
		input logic [31:0] fcon,
		input logic [31:0] trstat,
		input logic [7:0]  cnt,
		input logic [2:0]  chan
	);
		irq_eval_t   r;
		logic [31:0] mask;
		r.trstat = trstat;
		r.disarm = 1'b0;
		mask     = 32'h0000_0007;
		if (fcon[0]) begin
			if (con[13]) begin
				mask     = mask | 32'h0000_0020;
				r.trstat = r.trstat | 32'h0000_0020;
			end
			if (con[12]) begin
				mask = mask | 32'h0000_0010;
				if (cnt >= trig_level(chan, fcon[5:4])) begin
					r.trstat = r.trstat | 32'h0000_0010;
					r.disarm = 1'b1;
				end
			end
			if (con[9]) begin
				mask = mask | 32'h0000_0008;
			end
		end
		r.irq = |(r.trstat & mask);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/uartrb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module uartrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/uart_register_block_with_rx_fifo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART register block with receive FIFO
// Word-indexed register file, receive FIFO, receive timeout flag and
// interrupt line, driven by bus reads, bus writes and line events.
// ----------------------------------------------------------------------------
// Each input item is a bus read, a bus write, a received byte, a line break
// or a timeout expiry, and it produces exactly one result item with the read
// data, any transmitted byte, the interrupt level, whether a received byte was
// stored and whether the receive timeout is armed.
// An item accepted at one clock edge is executed in the following cycle and
// its result is valid after the next edge. Items are handled one at a time,
// so the block takes no new item while one executes: the registered read of
// the register RAM and of the FIFO RAM forces this. While a result is stalled
// at the output, the block finishes no further item; in_stall stays high
// until the waiting result is taken.
// Reset loads the control registers with their reset values and clears the
// FIFO pointers, interrupt line and timeout flag; plain registers read as zero
// until first written, with no clearing pass. The user must write the channel
// number through cfg_wr_en and cfg_wr_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module uart_register_block_with_rx_fifo_core #(
	parameter int RX_DEPTH = uartrb_pkg::RX_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [3:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic [7:0]  rx_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        tx_valid,
	output logic [7:0]  tx_data,
	output logic        irq_level,
	output logic        rx_accepted,
	output logic        timeout_armed
);

	import uartrb_pkg::*;

	localparam int HeadW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int CntW  = $clog2(RX_DEPTH + 1);
	localparam int SumW  = CntW + 1;

	state_t state_q, state_d;
	logic   accept;
	logic   exec;

	logic [2:0]  kind_s1;
	logic [3:0]  idx_s1;
	logic [31:0] wdata_s1;
	logic [7:0]  rxb_s1;

	logic [2:0]          chan_q;
	logic [31:0]         con_q, con_d;
	logic [31:0]         fcon_q, fcon_d;
	logic [31:0]         trstat_q, trstat_d;
	logic [31:0]         erstat_q, erstat_d;
	logic [7:0]          rxh_q, rxh_d;
	logic [HeadW-1:0]    head_q, head_d;
	logic [CntW-1:0]     cnt_q, cnt_d;
	logic                irq_q, irq_d;
	logic                armed_q, armed_d;
	logic [NUM_REGS-1:0] reg_vld_q;

	logic        out_valid_q;
	logic [31:0] rd_data_q;
	logic        tx_valid_q;
	logic [7:0]  tx_data_q;
	logic        irq_out_q;
	logic        rx_acc_q;
	logic        armed_out_q;

	logic [31:0] rd_data;
	logic        tx_v;
	logic [7:0]  tx_b;
	logic        rx_acc;
	logic        reg_we;
	logic        do_push;
	logic [7:0]  push_data;
	logic        do_eval;
	irq_eval_t   ev;

	logic [31:0]      reg_rdata;
	logic [7:0]       rx_rdata;
	logic [SumW-1:0]  pos_sum;
	logic [HeadW-1:0] push_pos;
	logic [SumW-1:0]  head_inc;
	logic [HeadW-1:0] head_next;
	logic             fifo_full;

	uartrb_ram #(
		.WIDTH (32),
		.DEPTH (NUM_REGS)
	) u_reg_ram (
		.clk   (clk),
		.we    (exec && reg_we),
		.waddr (idx_s1),
		.wdata (wdata_s1),
		.re    (accept),
		.raddr (reg_index),
		.rdata (reg_rdata)
	);

	uartrb_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (exec && do_push),
		.waddr (push_pos),
		.wdata (push_data),
		.re    (accept),
		.raddr (head_q),
		.rdata (rx_rdata)
	);

	assign accept = in_valid && !in_stall;
	assign exec   = (state_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
				if (in_valid && !in_stall) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			idx_s1   <= reg_index;
			wdata_s1 <= write_data;
			rxb_s1   <= rx_data;
		end
	end

	assign fifo_full = (SumW'(cnt_q) >= SumW'(RX_DEPTH));
	assign pos_sum   = SumW'(head_q) + SumW'(cnt_q);
	assign push_pos  = (pos_sum >= SumW'(RX_DEPTH)) ? HeadW'(pos_sum - SumW'(RX_DEPTH))
		: HeadW'(pos_sum);
	assign head_inc  = SumW'(head_q) + SumW'(1);
	assign head_next = (head_inc >= SumW'(RX_DEPTH)) ? '0 : HeadW'(head_inc);

	always_comb begin
		con_d     = con_q;
		fcon_d    = fcon_q;
		trstat_d  = trstat_q;
		erstat_d  = erstat_q;
		rxh_d     = rxh_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		armed_d   = armed_q;
		irq_d     = irq_q;
		rd_data   = 32'd0;
		tx_v      = 1'b0;
		tx_b      = 8'd0;
		rx_acc    = 1'b0;
		reg_we    = 1'b0;
		do_push   = 1'b0;
		push_data = rxb_s1;
		do_eval   = 1'b0;
		ev        = '0;
		case (kind_s1)
			KIND_READ: begin
				if (idx_s1 < 4'(NUM_REGS)) begin
					case (idx_s1)
						R_CON: rd_data = con_q;
						R_FCON: rd_data = fcon_q;
						R_TRSTAT: rd_data = trstat_q;
						R_ERSTAT: begin
							rd_data  = erstat_q;
							erstat_d = 32'd0;
						end
						R_FSTAT: begin
							rd_data = 32'(cnt_q) & FSTAT_CNT;
							if (fifo_full) begin
								rd_data = rd_data | FSTAT_FULL;
							end
						end
						R_MSTAT: rd_data = 32'd0;
						R_TXH: rd_data = 32'd0;
						R_RXH: begin
							if (fcon_q[0]) begin
								if (cnt_q != '0) begin
									rd_data     = {24'd0, rx_rdata};
									head_d      = head_next;
									cnt_d       = cnt_q - CntW'(1);
									trstat_d[0] = (cnt_d != '0);
								end
							end else begin
								trstat_d[0] = 1'b0;
								rd_data     = {24'd0, rxh_q};
							end
						end
						default: rd_data = reg_vld_q[idx_s1] ? reg_rdata : 32'd0;
					endcase
				end
			end
			KIND_WRITE: begin
				if (idx_s1 < 4'(NUM_REGS)) begin
					case (idx_s1)
						R_FCON: begin
							fcon_d = wdata_s1;
							if (wdata_s1[1]) begin
								head_d    = '0;
								cnt_d     = '0;
								fcon_d[1] = 1'b0;
							end
							if (wdata_s1[2]) begin
								fcon_d[2] = 1'b0;
							end
						end
						R_TXH: begin
							tx_v     = 1'b1;
							tx_b     = wdata_s1[7:0];
							trstat_d = trstat_q | 32'h0000_0006;
							do_eval  = 1'b1;
						end
						R_TRSTAT: begin
							trstat_d = trstat_q & ~wdata_s1;
							do_eval  = 1'b1;
						end
						R_CON: con_d = wdata_s1;
						R_ERSTAT, R_FSTAT, R_MSTAT, R_RXH: begin
						end
						default: reg_we = 1'b1;
					endcase
				end
			end
			KIND_RX_BYTE: begin
				if (fcon_q[0]) begin
					if (!fifo_full) begin
						do_push = 1'b1;
						cnt_d   = cnt_q + CntW'(1);
						armed_d = con_q[9];
						rx_acc  = 1'b1;
					end
				end else if (!trstat_q[0]) begin
					rxh_d  = rxb_s1;
					rx_acc = 1'b1;
				end
				if (rx_acc) begin
					trstat_d = trstat_q | 32'h0000_0001;
					do_eval  = 1'b1;
				end
			end
			KIND_BREAK: begin
				if (!fifo_full) begin
					do_push   = 1'b1;
					push_data = 8'd0;
					cnt_d     = cnt_q + CntW'(1);
				end
				erstat_d = erstat_q | 32'h0000_0008;
				do_eval  = 1'b1;
			end
			KIND_TIMEOUT: begin
				if (armed_q) begin
					armed_d = 1'b0;
					if (trstat_q[0] || con_q[9]) begin
						trstat_d = trstat_q | 32'h0000_0008;
						do_eval  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (do_eval) begin
			ev       = eval_irq(con_d, fcon_d, trstat_d, 8'(cnt_d), chan_q);
			trstat_d = ev.trstat;
			irq_d    = ev.irq;
			if (ev.disarm) begin
				armed_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q    <= 3'd0;
			con_q     <= CON_RESET;
			fcon_q    <= 32'd0;
			trstat_q  <= TRSTAT_RESET;
			erstat_q  <= 32'd0;
			rxh_q     <= 8'd0;
			head_q    <= '0;
			cnt_q     <= '0;
			irq_q     <= 1'b0;
			armed_q   <= 1'b0;
			reg_vld_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				chan_q <= cfg_wr_data;
			end
			if (exec) begin
				con_q    <= con_d;
				fcon_q   <= fcon_d;
				trstat_q <= trstat_d;
				erstat_q <= erstat_d;
				rxh_q    <= rxh_d;
				head_q   <= head_d;
				cnt_q    <= cnt_d;
				irq_q    <= irq_d;
				armed_q  <= armed_d;
				if (reg_we) begin
					reg_vld_q[idx_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rd_data_q   <= rd_data;
			tx_valid_q  <= tx_v;
			tx_data_q   <= tx_b;
			irq_out_q   <= irq_d;
			rx_acc_q    <= rx_acc;
			armed_out_q <= armed_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = rd_data_q;
	assign tx_valid      = tx_valid_q;
	assign tx_data       = tx_data_q;
	assign irq_level     = irq_out_q;
	assign rx_accepted   = rx_acc_q;
	assign timeout_armed = armed_out_q;

	a_exec_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> !out_valid_q)
		else $error("result register busy while an item executes");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> exec)
		else $error("accepted item did not enter execution");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SumW'(cnt_q) <= SumW'(RX_DEPTH)) && (SumW'(head_q) < SumW'(RX_DEPTH)))
		else $error("receive FIFO pointer out of range");

	a_tx_not_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tx_valid_q |-> !rx_acc_q && (rd_data_q == 32'd0))
		else $error("transmit result carries receive or read data");

endmodule
`default_nettype wire

>>> verif/uart_register_block_with_rx_fifo_core_checker.sv
// ----------------------------------------------------------------------------
// UART register block checker
// Watches the configuration port and both item channels of the UART register
// block. Each accepted input item is run through a register-level model of
// the register file, receive FIFO, timeout flag and interrupt line. Each
// accepted result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module uart_register_block_with_rx_fifo_core_checker #(
	parameter int RX_DEPTH = uartrb_pkg::RX_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [3:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic [7:0]  rx_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_data,
	input  logic        tx_valid,
	input  logic [7:0]  tx_data,
	input  logic        irq_level,
	input  logic        rx_accepted,
	input  logic        timeout_armed,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import uartrb_pkg::*;

	localparam logic [31:0] TXH_RESET   = 32'h5c5c_5c5c;
	localparam logic [31:0] IRQ_BASE    = 32'h0000_0007;
	localparam logic [31:0] ST_RX_READY = 32'h0000_0001;
	localparam logic [31:0] ST_TX_EMPTY = 32'h0000_0006;
	localparam logic [31:0] ST_TIMEOUT  = 32'h0000_0008;
	localparam logic [31:0] ST_RX_TRIG  = 32'h0000_0010;
	localparam logic [31:0] ST_TX_TRIG  = 32'h0000_0020;
	localparam logic [31:0] ER_BREAK    = 32'h0000_0008;
	localparam int          CON_TOUT_EN = 9;
	localparam int          CON_RX_INT  = 12;
	localparam int          CON_TX_INT  = 13;
	localparam int          FCON_EN     = 0;
	localparam int          FCON_RX_RST = 1;
	localparam int          FCON_TX_RST = 2;
	localparam int          MAX_REPORTS = 40;

	typedef struct packed {
		logic [31:0] rdata;
		logic        tx_v;
		logic [7:0]  tx_d;
		logic        irq;
		logic        rx_acc;
		logic        armed;
	} uart_result_t;

	logic [31:0]  regs [NUM_REGS];
	logic [7:0]   rx_mem [RX_DEPTH];
	int           rx_head;
	int           rx_count;
	logic         irq_line;
	logic         tout_armed;
	logic [2:0]   channel;
	uart_result_t result_q [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic int trigger_level(input logic [1:0] sel);
		int n;
		n = int'(sel) + 1;
		case (channel)
			3'd0: return n * 32;
			3'd1, 3'd4: return n * 8;
			3'd2, 3'd3: return n * 2;
			default: return 0;
		endcase
	endfunction

	task automatic update_irq();
		logic [31:0] mask;
		mask = IRQ_BASE;
		if (regs[R_FCON][FCON_EN]) begin
			if (regs[R_CON][CON_TX_INT]) begin
				mask = mask | ST_TX_TRIG;
				regs[R_TRSTAT] = regs[R_TRSTAT] | ST_TX_TRIG;
			end
			if (regs[R_CON][CON_RX_INT]) begin
				mask = mask | ST_RX_TRIG;
				if (rx_count >= trigger_level(regs[R_FCON][5:4])) begin
					regs[R_TRSTAT] = regs[R_TRSTAT] | ST_RX_TRIG;
					tout_armed = 1'b0;
				end
			end
			if (regs[R_CON][CON_TOUT_EN]) begin
				mask = mask | ST_TIMEOUT;
			end
		end
		irq_line = |(regs[R_TRSTAT] & mask);
	endtask

	task automatic push_rx(input logic [7:0] b);
		int pos;
		pos = rx_head + rx_count;
		if (pos >= RX_DEPTH) begin
			pos = pos - RX_DEPTH;
		end
		rx_mem[pos] = b;
		rx_count++;
	endtask

	task automatic read_reg(input logic [3:0] ix, output logic [31:0] d);
		d = '0;
		if (ix < NUM_REGS) begin
			case (ix)
				R_ERSTAT: begin
					d = regs[R_ERSTAT];
					regs[R_ERSTAT] = '0;
				end
				R_FSTAT: begin
					regs[R_FSTAT] = 32'(rx_count) & FSTAT_CNT;
					if (rx_count >= RX_DEPTH) begin
						regs[R_FSTAT] = regs[R_FSTAT] | FSTAT_FULL;
					end
					d = regs[R_FSTAT];
				end
				R_RXH: begin
					if (regs[R_FCON][FCON_EN]) begin
						if (rx_count != 0) begin
							d = {24'd0, rx_mem[rx_head]};
							rx_head = (rx_head + 1 >= RX_DEPTH) ? 0 : rx_head + 1;
							rx_count--;
							if (rx_count == 0) begin
								regs[R_TRSTAT] = regs[R_TRSTAT] & ~ST_RX_READY;
							end else begin
								regs[R_TRSTAT] = regs[R_TRSTAT] | ST_RX_READY;
							end
						end
					end else begin
						regs[R_TRSTAT] = regs[R_TRSTAT] & ~ST_RX_READY;
						d = regs[R_RXH];
					end
				end
				R_TXH: d = '0;
				default: d = regs[ix];
			endcase
		end
	endtask

	task automatic write_reg(input logic [3:0] ix, input logic [31:0] wd,
			inout uart_result_t r);
		if (ix < NUM_REGS) begin
			case (ix)
				R_FCON: begin
					regs[R_FCON] = wd;
					if (wd[FCON_RX_RST]) begin
						rx_head = 0;
						rx_count = 0;
						regs[R_FCON][FCON_RX_RST] = 1'b0;
					end
					if (wd[FCON_TX_RST]) begin
						regs[R_FCON][FCON_TX_RST] = 1'b0;
					end
				end
				R_TXH: begin
					r.tx_v = 1'b1;
					r.tx_d = wd[7:0];
					regs[R_TRSTAT] = regs[R_TRSTAT] | ST_TX_EMPTY;
					update_irq();
				end
				R_TRSTAT: begin
					regs[R_TRSTAT] = regs[R_TRSTAT] & ~wd;
					update_irq();
				end
				R_ERSTAT, R_FSTAT, R_MSTAT, R_RXH: ;
				default: regs[ix] = wd;
			endcase
		end
	endtask

	task automatic predict_item(input logic [2:0] k, input logic [3:0] ix,
			input logic [31:0] wd, input logic [7:0] rb, output uart_result_t r);
		logic [31:0] d;
		logic        take;
		r = '0;
		take = 1'b0;
		case (k)
			KIND_READ: begin
				read_reg(ix, d);
				r.rdata = d;
			end
			KIND_WRITE: write_reg(ix, wd, r);
			KIND_RX_BYTE: begin
				if (regs[R_FCON][FCON_EN]) begin
					if (rx_count < RX_DEPTH) begin
						push_rx(rb);
						tout_armed = regs[R_CON][CON_TOUT_EN];
						take = 1'b1;
					end
				end else if ((regs[R_TRSTAT] & ST_RX_READY) == '0) begin
					regs[R_RXH] = {24'd0, rb};
					take = 1'b1;
				end
				if (take) begin
					r.rx_acc = 1'b1;
					regs[R_TRSTAT] = regs[R_TRSTAT] | ST_RX_READY;
					update_irq();
				end
			end
			KIND_BREAK: begin
				if (rx_count < RX_DEPTH) begin
					push_rx(8'd0);
				end
				regs[R_ERSTAT] = regs[R_ERSTAT] | ER_BREAK;
				update_irq();
			end
			KIND_TIMEOUT: begin
				if (tout_armed) begin
					tout_armed = 1'b0;
					if ((regs[R_TRSTAT] & ST_RX_READY) != '0 || regs[R_CON][CON_TOUT_EN]) begin
						regs[R_TRSTAT] = regs[R_TRSTAT] | ST_TIMEOUT;
						update_irq();
					end
				end
			end
			default: ;
		endcase
		r.irq = irq_line;
		r.armed = tout_armed;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		uart_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs[i] = '0;
			end
			regs[R_CON] = CON_RESET;
			regs[R_TRSTAT] = TRSTAT_RESET;
			regs[R_TXH] = TXH_RESET;
			for (int i = 0; i < RX_DEPTH; i++) begin
				rx_mem[i] = '0;
			end
			rx_head = 0;
			rx_count = 0;
			irq_line = 1'b0;
			tout_armed = 1'b0;
			channel = '0;
			result_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result, read_data", read_data, '0);
				end else begin
					want = result_q.pop_front();
					if (read_data !== want.rdata) begin
						report_mismatch("read_data", read_data, want.rdata);
					end
					if (tx_valid !== want.tx_v) begin
						report_mismatch("tx_valid", 32'(tx_valid), 32'(want.tx_v));
					end
					if (tx_data !== want.tx_d) begin
						report_mismatch("tx_data", 32'(tx_data), 32'(want.tx_d));
					end
					if (irq_level !== want.irq) begin
						report_mismatch("irq_level", 32'(irq_level), 32'(want.irq));
					end
					if (rx_accepted !== want.rx_acc) begin
						report_mismatch("rx_accepted", 32'(rx_accepted), 32'(want.rx_acc));
					end
					if (timeout_armed !== want.armed) begin
						report_mismatch("timeout_armed", 32'(timeout_armed),
							32'(want.armed));
					end
				end
			end
			if (cfg_wr_en) begin
				channel = cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				predict_item(kind, reg_index, write_data, rx_data, want);
				result_q.push_back(want);
			end
			pending <= result_q.size();
		end
	end

endmodule

>>> verif/uart_register_block_with_rx_fifo_core_tb.sv
// ----------------------------------------------------------------------------
// UART register block testbench
// Drives bus reads, bus writes, received bytes, breaks and timeout expiries
// into the UART register block under every channel setting, with random
// idling on both channels and one long output hold-off. A checker beside the
// block predicts and compares every result item; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module uart_register_block_with_rx_fifo_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uartrb_pkg::*;

	localparam int         CYCLE_LIMIT = 200000;
	localparam int         LONG_HOLD   = 300;
	localparam int         PHASE_ITEMS = 62;
	localparam int         NUM_PHASES  = 8;
	localparam logic [2:0] KIND_MAX    = 3'd7;
	localparam logic [3:0] REG_LCON    = 4'd0;
	localparam logic [3:0] REG_SCRATCH = 4'd12;
	localparam logic [3:0] REG_NONE    = 4'd15;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [3:0]  reg_index;
	logic [31:0] write_data;
	logic [7:0]  rx_data;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	logic        tx_valid;
	logic [7:0]  tx_data;
	logic        irq_level;
	logic        rx_accepted;
	logic        timeout_armed;

	int          mismatches;
	int          pending;
	int          cycles;
	int          phase_items;
	bit          calm;
	bit          hold_req;
	logic [2:0]  channel_plan [NUM_PHASES] = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

	uart_register_block_with_rx_fifo_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.reg_index     (reg_index),
		.write_data    (write_data),
		.rx_data       (rx_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.tx_valid      (tx_valid),
		.tx_data       (tx_data),
		.irq_level     (irq_level),
		.rx_accepted   (rx_accepted),
		.timeout_armed (timeout_armed)
	);

	uart_register_block_with_rx_fifo_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.reg_index     (reg_index),
		.write_data    (write_data),
		.rx_data       (rx_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.tx_valid      (tx_valid),
		.tx_data       (tx_data),
		.irq_level     (irq_level),
		.rx_accepted   (rx_accepted),
		.timeout_armed (timeout_armed),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [3:0] rand_index();
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] fcon_word();
		logic [31:0] v;
		v = $urandom;
		v[0] = ($urandom_range(0, 4) != 0);
		v[1] = ($urandom_range(0, 6) == 0);
		return v;
	endfunction

	task automatic send_item(input logic [2:0] k, input logic [3:0] ix,
			input logic [31:0] wd, input logic [7:0] rb);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		reg_index <= ix;
		write_data <= wd;
		rx_data <= rb;
		do @(posedge clk); while (in_stall);
		phase_items++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_channel(input logic [2:0] ch);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ch;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_directed();
		send_item(KIND_READ, R_CON, '0, '0);
		send_item(KIND_READ, R_TRSTAT, '0, '0);
		send_item(KIND_READ, R_TXH, '0, '0);
		send_item(KIND_READ, REG_NONE, '0, '0);
		send_item(KIND_WRITE, REG_NONE, 32'hffff_ffff, 8'hff);
		send_item(KIND_WRITE, R_ERSTAT, 32'hffff_ffff, 8'hff);
		send_item(KIND_WRITE, REG_SCRATCH, 32'hffff_ffff, 8'hff);
		send_item(KIND_READ, REG_SCRATCH, '0, '0);
		send_item(KIND_WRITE, REG_SCRATCH, '0, '0);
		send_item(KIND_TIMEOUT + 3'd1, REG_NONE, 32'hffff_ffff, 8'hff);
		send_item(KIND_MAX, REG_NONE, 32'hffff_ffff, 8'hff);
		// With the FIFO off, a second byte is dropped until the first is read.
		send_item(KIND_RX_BYTE, REG_LCON, '0, 8'hff);
		send_item(KIND_RX_BYTE, REG_LCON, '0, 8'h00);
		send_item(KIND_READ, R_RXH, '0, '0);
		send_item(KIND_WRITE, R_FCON, 32'h0000_0001, '0);
		send_item(KIND_WRITE, R_CON, 32'h0000_3200, '0);
		send_item(KIND_RX_BYTE, REG_LCON, '0, 8'ha5);
		send_item(KIND_TIMEOUT, REG_LCON, '0, '0);
		send_item(KIND_TIMEOUT, REG_LCON, '0, '0);
		send_item(KIND_READ, R_RXH, '0, '0);
		send_item(KIND_READ, R_RXH, '0, '0);
		send_item(KIND_BREAK, REG_LCON, '0, '0);
		send_item(KIND_READ, R_ERSTAT, '0, '0);
		send_item(KIND_READ, R_FSTAT, '0, '0);
		send_item(KIND_WRITE, R_TXH, 32'hffff_ff5a, '0);
		send_item(KIND_WRITE, R_TRSTAT, 32'hffff_ffff, '0);
		send_item(KIND_WRITE, R_FCON, 32'h0000_0037, '0);
	endtask

	task automatic run_sequence();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			n = $urandom_range(3, 18);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(KIND_BREAK, rand_index(), $urandom, rand_byte());
				end else begin
					send_item(KIND_RX_BYTE, rand_index(), $urandom, rand_byte());
				end
			end
		end else if (pick < 45) begin
			n = $urandom_range(2, 12);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					send_item(KIND_READ, R_FSTAT, $urandom, rand_byte());
				end else begin
					send_item(KIND_READ, R_RXH, $urandom, rand_byte());
				end
			end
		end else if (pick < 58) begin
			send_item(KIND_WRITE, R_CON, $urandom, rand_byte());
			send_item(KIND_WRITE, R_FCON, fcon_word(), rand_byte());
			if ($urandom_range(0, 1) == 0) begin
				n = $urandom_range(0, 4);
				send_item(KIND_WRITE, (n == 0) ? REG_LCON : REG_SCRATCH, $urandom, rand_byte());
				send_item(KIND_READ, (n == 0) ? REG_LCON : REG_SCRATCH, $urandom, rand_byte());
			end
		end else if (pick < 75) begin
			case ($urandom_range(0, 5))
				0: send_item(KIND_READ, R_TRSTAT, $urandom, rand_byte());
				1: send_item(KIND_WRITE, R_TRSTAT, $urandom, rand_byte());
				2: send_item(KIND_READ, R_ERSTAT, $urandom, rand_byte());
				3: send_item(KIND_READ, R_FSTAT, $urandom, rand_byte());
				4: send_item(KIND_WRITE, R_TXH, $urandom, rand_byte());
				default: send_item(KIND_READ, R_MSTAT, $urandom, rand_byte());
			endcase
		end else if (pick < 90) begin
			send_item(KIND_RX_BYTE, rand_index(), $urandom, rand_byte());
			send_item(KIND_TIMEOUT, rand_index(), $urandom, rand_byte());
			if ($urandom_range(0, 1) == 0) begin
				send_item(KIND_TIMEOUT, rand_index(), $urandom, rand_byte());
			end
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				send_item(3'($urandom_range(0, KIND_MAX)), rand_index(), $urandom, rand_byte());
			end
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_READ;
		reg_index <= '0;
		write_data <= '0;
		rx_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_channel(channel_plan[p]);
			if (p == 0) begin
				run_directed();
			end
			if (p == 2) begin
				hold_req = 1'b1;
			end
			if (p == NUM_PHASES - 1) begin
				calm = 1'b1;
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) run_sequence();
		end
		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/uartrb_pkg.sv
rtl/uartrb_ram.sv
rtl/uart_register_block_with_rx_fifo_core.sv
verif/uart_register_block_with_rx_fifo_core_checker.sv
verif/uart_register_block_with_rx_fifo_core_tb.sv
